// ----- rtl/core/aescbc_pkg.sv -----
// Shared types, constants and AES round functions for the CBC byte-stream cipher.
`default_nettype none

package aescbc_pkg;

  localparam int NumRk = 11;
  localparam int RkIdxW = $clog2(NumRk);

  localparam logic [127:0] KeyRst = 128'h23544452_65646973_2d2d3e32_30323123;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_KEY0 = 3'd1,
    REG_KEY1 = 3'd2,
    REG_KEY2 = 3'd3,
    REG_KEY3 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic dec;
  } aes_ctl_t;

  localparam logic [2047:0] Sbox = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] InvSbox = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sb(input logic [7:0] x);
    return Sbox[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] isb(input logic [7:0] x);
    return InvSbox[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [127:0] v, input logic [3:0] k);
    return v[{~k, 3'b000} +: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic fin);
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = sb(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) u[c*4+i] = t[((c+i)%4)*4+i];
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
        u[c*4]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        u[c*4+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        u[c*4+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        u[c*4+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = u[i];
    return r ^ k;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [1:0] sel);
    logic [7:0] x2, x4, x8, r;
    x2 = xt(a);
    x4 = xt(x2);
    x8 = xt(x4);
    case (sel)
      2'd0:    r = x8 ^ a;
      2'd1:    r = x8 ^ x2 ^ a;
      2'd2:    r = x8 ^ x4 ^ a;
      default: r = x8 ^ x4 ^ x2;
    endcase
    return r;
  endfunction

  // gm selectors: 0 is times 9, 1 times 11, 2 times 13, 3 times 14.
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic fin);
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) u[c*4+i] = isb(t[((c+4-i)%4)*4+i]);
    for (int i = 0; i < 16; i++) u[i] = u[i] ^ k[127-8*i -: 8];
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
        u[c*4]   = gm(a0, 2'd3) ^ gm(a1, 2'd1) ^ gm(a2, 2'd2) ^ gm(a3, 2'd0);
        u[c*4+1] = gm(a0, 2'd0) ^ gm(a1, 2'd3) ^ gm(a2, 2'd1) ^ gm(a3, 2'd2);
        u[c*4+2] = gm(a0, 2'd2) ^ gm(a1, 2'd0) ^ gm(a2, 2'd3) ^ gm(a3, 2'd1);
        u[c*4+3] = gm(a0, 2'd1) ^ gm(a1, 2'd2) ^ gm(a2, 2'd0) ^ gm(a3, 2'd3);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = u[i];
    return r;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] w, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t = {sb(w[23:16]), sb(w[15:8]), sb(w[7:0]), sb(w[31:24])} ^ {rc, 24'h0};
    n0 = w[127:96] ^ t;
    n1 = w[95:64] ^ n0;
    n2 = w[63:32] ^ n1;
    n3 = w[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/aescbc_kexp.sv -----
// Iterative AES-128 key expansion and round key store.
`default_nettype none

module aescbc_kexp import aescbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [127:0]      key,
  input  wire logic [RkIdxW-1:0] rd_idx,
  output logic [127:0]           rd_key,
  output logic                   busy
);

  logic [127:0]      rk_r [NumRk];
  logic [127:0]      cur_r;
  logic [7:0]        rcon_r;
  logic [RkIdxW-1:0] idx_r;
  logic              busy_r;
  logic [127:0]      cur_nxt;

  assign cur_nxt = key_step(cur_r, rcon_r);
  assign rd_key  = rk_r[rd_idx];
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && idx_r == RkIdxW'(NumRk - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rk_r[0] <= key;
      cur_r   <= key;
      rcon_r  <= 8'h01;
      idx_r   <= RkIdxW'(1);
    end else if (busy_r) begin
      rk_r[idx_r] <= cur_nxt;
      cur_r       <= cur_nxt;
      rcon_r      <= xt(rcon_r);
      idx_r       <= idx_r + RkIdxW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/aescbc_rnd.sv -----
// Shared AES round unit, one round per cycle for encryption or decryption.
`default_nettype none

module aescbc_rnd import aescbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aes_ctl_t          ctl,
  input  wire logic [127:0]      blk_in,
  input  wire logic [127:0]      rk,
  output logic [RkIdxW-1:0]      rk_idx,
  output logic [127:0]           blk_out,
  output logic                   done
);

  localparam logic [RkIdxW-1:0] LastRnd = RkIdxW'(NumRk - 1);

  logic              busy_r;
  logic              done_r;
  logic              dec_r;
  logic [RkIdxW-1:0] rnd_r;
  logic [127:0]      s_r;
  logic              fin;

  assign fin     = (rnd_r == LastRnd);
  assign rk_idx  = !busy_r ? (ctl.dec ? LastRnd : '0) : (dec_r ? LastRnd - rnd_r : rnd_r);
  assign blk_out = s_r;
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !ctl.start && busy_r && fin;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && fin) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      s_r   <= blk_in ^ rk;
      dec_r <= ctl.dec;
      rnd_r <= RkIdxW'(1);
    end else if (busy_r) begin
      s_r   <= dec_r ? dec_round(s_r, rk, fin) : enc_round(s_r, rk, fin);
      rnd_r <= rnd_r + RkIdxW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/aes_cbc_byte_stream_cipher_unit.sv -----
// Top level of the AES-128 CBC byte-stream cipher with zero IV.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | in_data_byte, in_last_byte
//   out_    | output    | out_valid / out_stall | out_byte, out_last, out_error
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A byte inside a block is accepted on its own. A byte that closes a block, or a last
// byte in encryption, runs the shared round unit, then its result items go out one per
// cycle without stall, and the burst then closes.
// After reset, and after each key write, key expansion holds in_stall while it runs.
// Reset is synchronous and active low; out_stall only holds the burst in place.
`default_nettype none

module aes_cbc_byte_stream_cipher_unit import aescbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_AES  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t       st_r;
  logic         mode_r;
  logic [127:0] key_r;
  logic         kick_r;
  logic [3:0]   pos_r;
  logic         held_v_r;
  logic [127:0] chain_r, gath_r, held_r, pt_r;
  logic [4:0]   lena_r, lenb_r;
  logic         xtra_r, xerr_r, end_r;
  logic [7:0]   xbyte_r;
  logic [5:0]   cnt_r;

  logic              kbusy;
  logic [127:0]      rk;
  logic [RkIdxW-1:0] rk_idx;
  aes_ctl_t          actl;
  logic [127:0]      aes_out;
  logic              aes_done;

  logic         acc, cfg_wr, key_wr;
  logic [127:0] enc_blk, gath_new, aes_in;
  logic         blk_end, cnt_ok;
  logic [5:0]   total, endb;
  logic         in_a, in_b;
  logic [3:0]   kb;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_wr    = cfg_wr && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                cfg_index == REG_KEY2 || cfg_index == REG_KEY3);
  assign in_stall  = (st_r != ST_IDLE) || kick_r || kbusy;
  assign acc       = in_valid && !in_stall;

  always_comb begin
    enc_blk  = chain_r;
    gath_new = gath_r;
    for (int k = 0; k < 16; k++) begin
      if (pos_r == 4'(k)) begin
        enc_blk[127-8*k -: 8]  = chain_r[127-8*k -: 8] ^ in_data_byte;
        gath_new[127-8*k -: 8] = in_data_byte;
      end
    end
  end

  assign blk_end    = (pos_r == 4'd15);
  assign cnt_ok     = (in_data_byte[7:4] == 4'd0) && (in_data_byte != 8'd0);
  assign aes_in     = mode_r ? gath_new : enc_blk;
  assign actl.dec   = mode_r;
  assign actl.start = acc && (blk_end || (!mode_r && in_last_byte));

  aescbc_kexp u_kexp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (kick_r),
    .key    (key_r),
    .rd_idx (rk_idx),
    .rd_key (rk),
    .busy   (kbusy)
  );

  aescbc_rnd u_rnd (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (actl),
    .blk_in  (aes_in),
    .rk      (rk),
    .rk_idx  (rk_idx),
    .blk_out (aes_out),
    .done    (aes_done)
  );

  assign total = {1'b0, lena_r} + {1'b0, lenb_r} + {5'd0, xtra_r};
  assign endb  = {1'b0, lena_r} + {1'b0, lenb_r};
  assign in_a  = cnt_r < {1'b0, lena_r};
  assign in_b  = cnt_r < endb;
  assign kb    = 4'(cnt_r - {1'b0, lena_r});

  assign out_valid = (st_r == ST_OUT) && (cnt_r != total);
  assign out_byte  = in_a ? get_byte(mode_r ? held_r : chain_r, cnt_r[3:0]) :
                     in_b ? get_byte(pt_r, kb) : xbyte_r;
  assign out_error = !in_b && xerr_r;
  assign out_last  = end_r && (cnt_r == total - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      key_r  <= KeyRst;
      kick_r <= 1'b1;
    end else begin
      kick_r <= key_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_MODE: mode_r <= cfg_data[0];
          REG_KEY0: key_r[127:96] <= cfg_data;
          REG_KEY1: key_r[95:64]  <= cfg_data;
          REG_KEY2: key_r[63:32]  <= cfg_data;
          REG_KEY3: key_r[31:0]   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      pos_r    <= 4'd0;
      held_v_r <= 1'b0;
      chain_r  <= '0;
    end else if (cfg_wr && (key_wr || cfg_index == REG_MODE)) begin
      st_r     <= ST_IDLE;
      pos_r    <= 4'd0;
      held_v_r <= 1'b0;
      chain_r  <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (actl.start) begin
            st_r <= ST_AES;
          end else if (acc) begin
            if (in_last_byte) begin
              st_r <= ST_OUT;
            end else begin
              pos_r <= pos_r + 4'd1;
              if (!mode_r) begin
                chain_r <= enc_blk;
              end
            end
          end
        end
        ST_AES: begin
          if (aes_done) begin
            st_r    <= ST_OUT;
            chain_r <= mode_r ? gath_r : aes_out;
          end
        end
        ST_OUT: begin
          if (cnt_r == total) begin
            st_r  <= ST_IDLE;
            pos_r <= 4'd0;
            if (end_r) begin
              chain_r  <= '0;
              held_v_r <= 1'b0;
            end else if (mode_r) begin
              held_v_r <= 1'b1;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      gath_r <= gath_new;
      cnt_r  <= 6'd0;
      end_r  <= in_last_byte;
      if (!mode_r) begin
        lena_r  <= 5'd16;
        lenb_r  <= 5'd0;
        xtra_r  <= in_last_byte && !blk_end;
        xerr_r  <= 1'b0;
        xbyte_r <= {4'd0, pos_r} + 8'd1;
      end else if (blk_end) begin
        lena_r  <= held_v_r ? 5'd16 : 5'd0;
        lenb_r  <= in_last_byte ? 5'd16 : 5'd0;
        xtra_r  <= 1'b0;
        xerr_r  <= 1'b0;
        xbyte_r <= 8'd0;
      end else if (pos_r == 4'd0 && held_v_r && cnt_ok) begin
        lena_r  <= in_data_byte[4:0];
        lenb_r  <= 5'd0;
        xtra_r  <= 1'b0;
        xerr_r  <= 1'b0;
        xbyte_r <= 8'd0;
      end else begin
        lena_r  <= 5'd0;
        lenb_r  <= 5'd0;
        xtra_r  <= 1'b1;
        xerr_r  <= 1'b1;
        xbyte_r <= 8'd0;
      end
    end else if (st_r == ST_OUT && out_valid && !out_stall) begin
      cnt_r <= cnt_r + 6'd1;
    end
    if (st_r == ST_AES && aes_done) begin
      pt_r <= aes_out ^ chain_r;
    end
    if (st_r == ST_OUT && cnt_r == total && !end_r && mode_r) begin
      held_r <= pt_r;
    end
  end

  a_done_in_aes: assert property (@(posedge clk) disable iff (!rst_n)
    aes_done |-> st_r == ST_AES)
    else $error("round unit finished outside a block operation");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> out_last)
    else $error("error item is not the final item");

  a_no_accept_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (kbusy || kick_r) |-> in_stall)
    else $error("item accepted during key expansion");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |-> cnt_r <= total)
    else $error("output count ran past burst length");

endmodule

`default_nettype wire

// ----- dv/aes_cbc_byte_stream_cipher_checker.sv -----
// Checker for the AES-128 CBC byte-stream cipher: watches the channels, predicts and compares.
module aes_cbc_byte_stream_cipher_checker import aescbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        out_error,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } cipher_out_t;

  localparam logic [7:0] MulNine = 8'd9;

  cipher_out_t expected_bytes[$];
  logic [7:0]  sbox_tab [256];
  logic [7:0]  inv_tab [256];
  logic        decrypt_mode;
  logic [31:0] key_regs [4];
  logic [7:0]  rkey [176];
  logic [7:0]  chain [16];
  logic [7:0]  gather [16];
  logic [7:0]  held [16];
  logic [3:0]  pos;
  logic        held_ok;

  function automatic logic [7:0] mul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = mul2(a);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] a);
    logic [7:0] r;
    r = 1;
    for (int i = 0; i < 254; i++) r = gf_mul(r, a);
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int s);
    return (v << s) | (v >> (8 - s));
  endfunction

  task automatic build_tables();
    logic [7:0] q;
    for (int i = 0; i < 256; i++) begin
      q = (i == 0) ? 8'h00 : gf_inv(8'(i));
      sbox_tab[i] = q ^ rol8(q, 1) ^ rol8(q, 2) ^ rol8(q, 3) ^ rol8(q, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_tab[sbox_tab[i]] = 8'(i);
  endtask

  task automatic expand_key();
    logic [7:0] t [4];
    logic [7:0] tmp, rc;
    rc = 1;
    for (int i = 0; i < 16; i++) rkey[i] = key_regs[i / 4][31 - 8 * (i % 4) -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rkey[(i - 1) * 4 + j];
      if (i % 4 == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int j = 0; j < 4; j++) t[j] = sbox_tab[t[j]];
        t[0] ^= rc;
        rc = mul2(rc);
      end
      for (int j = 0; j < 4; j++) rkey[i * 4 + j] = rkey[(i - 4) * 4 + j] ^ t[j];
    end
  endtask

  task automatic encrypt_block(inout logic [7:0] s [16]);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) s[i] ^= rkey[i];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) t[i] = sbox_tab[s[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) s[c * 4 + i] = t[((c + i) % 4) * 4 + i];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
          s[c*4]   = mul2(a0) ^ mul2(a1) ^ a1 ^ a2 ^ a3;
          s[c*4+1] = a0 ^ mul2(a1) ^ mul2(a2) ^ a2 ^ a3;
          s[c*4+2] = a0 ^ a1 ^ mul2(a2) ^ mul2(a3) ^ a3;
          s[c*4+3] = mul2(a0) ^ a0 ^ a1 ^ a2 ^ mul2(a3);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rkey[r * 16 + i];
    end
  endtask

  task automatic decrypt_block(inout logic [7:0] s [16]);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) s[i] ^= rkey[160 + i];
    for (int r = 10; r >= 1; r--) begin
      t = s;
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) s[c * 4 + i] = inv_tab[t[((c + 4 - i) % 4) * 4 + i]];
      for (int i = 0; i < 16; i++) s[i] ^= rkey[(r - 1) * 16 + i];
      if (r != 1) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
          s[c*4]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, MulNine);
          s[c*4+1] = gf_mul(a0, MulNine) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
          s[c*4+2] = gf_mul(a0, 13) ^ gf_mul(a1, MulNine) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
          s[c*4+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, MulNine) ^ gf_mul(a3, 14);
        end
      end
    end
  endtask

  task automatic start_message();
    for (int i = 0; i < 16; i++) chain[i] = 0;
    pos = 0;
    held_ok = 0;
  endtask

  task automatic push_byte(logic [7:0] d, logic l, logic e);
    expected_bytes.push_back('{data: d, last: l, err: e});
  endtask

  task automatic predict_byte(logic [7:0] d, logic l);
    logic [7:0] b [16];
    logic [7:0] pt [16];
    if (!decrypt_mode) begin
      b = chain;
      b[pos] ^= d;
      if (pos == 15 || l) begin
        encrypt_block(b);
        for (int i = 0; i < 16; i++) push_byte(b[i], l && pos == 15 && i == 15, 1'b0);
        if (l && pos != 15) push_byte(8'(pos) + 8'd1, 1'b1, 1'b0);
      end
      chain = b;
      if (l) start_message();
      else pos = pos + 1;
    end else if (pos == 15) begin
      gather[15] = d;
      pt = gather;
      decrypt_block(pt);
      for (int i = 0; i < 16; i++) pt[i] ^= chain[i];
      chain = gather;
      if (held_ok) for (int i = 0; i < 16; i++) push_byte(held[i], 1'b0, 1'b0);
      if (l) begin
        for (int i = 0; i < 16; i++) push_byte(pt[i], i == 15, 1'b0);
        start_message();
      end else begin
        held = pt;
        held_ok = 1;
        pos = 0;
      end
    end else if (!l) begin
      gather[pos] = d;
      pos = pos + 1;
    end else begin
      if (pos == 0 && held_ok && d >= 1 && d <= 15) begin
        for (int i = 0; i < d; i++) push_byte(held[i], i + 1 == d, 1'b0);
      end else begin
        push_byte(8'h00, 1'b1, 1'b1);
      end
      start_message();
    end
  endtask

  initial begin
    build_tables();
  end

  always @(posedge clk) begin
    cipher_out_t want;
    if (!rst_n) begin
      decrypt_mode = 0;
      for (int i = 0; i < 4; i++) key_regs[i] = KeyRst[127 - 32 * i -: 32];
      expand_key();
      start_message();
      expected_bytes.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected item byte=%h last=%b error=%b", $time, out_byte,
                   out_last, out_error);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (want !== {out_byte, out_last, out_error}) begin
            $display("%0t: expected byte=%h last=%b error=%b, got byte=%h last=%b error=%b",
                     $time, want.data, want.last, want.err, out_byte, out_last, out_error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(in_data_byte, in_last_byte);
      if (cfg_valid && cfg_ready && cfg_index <= REG_KEY3) begin
        if (cfg_index == REG_MODE) decrypt_mode = cfg_data[0];
        else key_regs[cfg_index - 1] = cfg_data;
        expand_key();
        start_message();
      end
    end
    pending_count = expected_bytes.size();
  end
endmodule

// ----- dv/tb_aes_cbc_byte_stream_cipher_unit.sv -----
// Testbench top for the AES-128 CBC byte-stream cipher: stimulus, configuration and verdict.
module tb_aes_cbc_byte_stream_cipher_unit import aescbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 4000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 0;
  logic        in_last_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_error;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;
  int          stall_pct = 34;
  int          gap_pct = 34;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  aes_cbc_byte_stream_cipher_unit dut (.*);

  aes_cbc_byte_stream_cipher_checker checker_inst (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("aes_cbc_byte_stream_cipher_unit verification failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] d, logic l);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_data_byte <= d;
    in_last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(int len, logic force_count, logic [7:0] count);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
    if (force_count) send_byte(count, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_traffic(int budget);
    int sent;
    int blocks;
    int calm;
    sent = 0;
    calm = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0: begin
          blocks = $urandom_range(1, 40);
          send_message(blocks, 1'b0, 0);
          sent += blocks;
        end
        1, 2: begin
          blocks = 16 * $urandom_range(1, 3);
          send_message(blocks, 1'b1, 8'($urandom_range(0, 17)));
          sent += blocks + 1;
        end
        default: begin
          blocks = 16 * $urandom_range(1, 3);
          send_message(blocks, 1'b1, 8'($urandom_range(1, 15)));
          sent += blocks + 1;
        end
      endcase
      if (sent >= budget / 2 && calm < 3) begin
        calm++;
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 34;
        stall_pct = 34;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_byte(8'h00, 1'b1);
    send_message(16, 1'b0, 0);
    send_byte(8'hff, 1'b0);
    send_message(14, 1'b0, 0);
    send_byte(8'h7e, 1'b1);
    random_traffic(70);
    write_reg(REG_MODE, 32'd1);
    send_message(16, 1'b1, 8'd1);
    send_message(32, 1'b1, 8'd15);
    send_message(16, 1'b1, 8'd0);
    send_message(16, 1'b1, 8'd16);
    send_message(16, 1'b1, 8'hff);
    send_message(1, 1'b0, 0);
    send_message(5, 1'b0, 0);
    send_message(16, 1'b0, 0);
    random_traffic(70);
    write_reg(REG_KEY0, 32'h0);
    write_reg(REG_KEY1, 32'h0);
    write_reg(REG_KEY2, 32'h0);
    write_reg(REG_KEY3, 32'h0);
    random_traffic(30);
    write_reg(REG_KEY0, 32'hffff_ffff);
    write_reg(REG_KEY1, 32'hffff_ffff);
    write_reg(REG_KEY2, $urandom);
    write_reg(REG_KEY3, 32'hffff_ffff);
    write_reg(REG_MODE, 32'd0);
    random_traffic(30);
    write_reg(REG_MODE, 32'hffff_fffe);
    send_message(7, 1'b0, 0);
    drain();
    if (fail_count == 0)
      $display("aes_cbc_byte_stream_cipher_unit verification clean");
    else
      $display("aes_cbc_byte_stream_cipher_unit verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/aescbc_pkg.sv
rtl/core/aescbc_kexp.sv
rtl/core/aescbc_rnd.sv
rtl/core/aes_cbc_byte_stream_cipher_unit.sv
dv/aes_cbc_byte_stream_cipher_checker.sv
dv/tb_aes_cbc_byte_stream_cipher_unit.sv
